### rtl/aabbs_pkg.sv
// shared constants and types for the bounding sphere block
package aabbs_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int OUT_WIDTH       = 32;
    localparam int AXES            = 3;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_ROOT,
        BK_DONE
    } back_state_t;

endpackage

### rtl/aabb_bounding_sphere.sv
// top level: bounding sphere of the axis-aligned box over a vertex stream
// Usage:
//   s_ channel takes one vertex per request (x, y, z in signed Q16.16 and a
//   last_vertex flag); only the low COORD_WIDTH bits of each coordinate count.
//   The front keeps a running min/max per axis and accepts one vertex every
//   cycle while s_ready is high. The vertex flagged last closes the set: its
//   box goes into a two-entry queue and the bounds return to their extremes.
//   m_ channel gives one request per closed set: centre (min+max)>>>1 per axis
//   and radius floor(sqrt(dx^2+dy^2+dz^2))>>1.
//   From the last vertex to m_valid a set passes the queue, a pop, the three
//   registered squares and their sum, then the bit-serial root, one bit per
//   cycle. The root unit handles one set at a time and hands over its result
//   from a done state; it takes no new box until the receiver has taken it.
//   Reset (aresetn low at a clock edge) empties the queue, idles the back end
//   and sets the bounds to their extremes.
//   When the receiver stalls the result holds on m_; the front keeps taking
//   vertices and s_ready falls only when a set closes with the queue full.
module aabb_bounding_sphere #(
    parameter int COORD_WIDTH = aabbs_pkg::COORD_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [aabbs_pkg::OUT_WIDTH-1:0]  s_vertex_x,
    input  logic [aabbs_pkg::OUT_WIDTH-1:0]  s_vertex_y,
    input  logic [aabbs_pkg::OUT_WIDTH-1:0]  s_vertex_z,
    input  logic                             s_last_vertex,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [aabbs_pkg::OUT_WIDTH-1:0]  m_center_x,
    output logic [aabbs_pkg::OUT_WIDTH-1:0]  m_center_y,
    output logic [aabbs_pkg::OUT_WIDTH-1:0]  m_center_z,
    output logic [aabbs_pkg::OUT_WIDTH-1:0]  m_sphere_radius
);
    import aabbs_pkg::*;

    localparam int BOX_W = 6 * COORD_WIDTH;

    logic             push_valid, push_ready;
    logic [BOX_W-1:0] push_data;
    logic             pop_valid, pop_ready;
    logic [BOX_W-1:0] pop_data;

    aabbs_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_vertex_x    (s_vertex_x),
        .s_vertex_y    (s_vertex_y),
        .s_vertex_z    (s_vertex_z),
        .s_last_vertex (s_last_vertex),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    aabbs_queue #(
        .DATA_WIDTH (BOX_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    aabbs_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_data        (pop_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_center_x      (m_center_x),
        .m_center_y      (m_center_y),
        .m_center_z      (m_center_z),
        .m_sphere_radius (m_sphere_radius)
    );

endmodule

### rtl/aabbs_front.sv
// front end: running per-axis min/max, hands a closed box to the queue
module aabbs_front #(
    parameter int COORD_WIDTH = aabbs_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [aabbs_pkg::OUT_WIDTH-1:0]      s_vertex_x,
    input  logic [aabbs_pkg::OUT_WIDTH-1:0]      s_vertex_y,
    input  logic [aabbs_pkg::OUT_WIDTH-1:0]      s_vertex_z,
    input  logic                                 s_last_vertex,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output logic [6*COORD_WIDTH-1:0]             push_data
);
    import aabbs_pkg::*;

    localparam logic signed [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] NEG_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COORD_WIDTH-1:0] lo_reg   [AXES];
    logic signed [COORD_WIDTH-1:0] hi_reg   [AXES];
    logic signed [COORD_WIDTH-1:0] lo_next  [AXES];
    logic signed [COORD_WIDTH-1:0] hi_next  [AXES];
    logic signed [COORD_WIDTH-1:0] vtx      [AXES];
    logic                          accept;

    assign vtx[0] = s_vertex_x[COORD_WIDTH-1:0];
    assign vtx[1] = s_vertex_y[COORD_WIDTH-1:0];
    assign vtx[2] = s_vertex_z[COORD_WIDTH-1:0];

    // only a closing vertex needs room in the queue
    assign s_ready    = push_ready || !s_last_vertex;
    assign accept     = s_valid && s_ready;
    assign push_valid = s_valid && s_last_vertex;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            lo_next[a] = (vtx[a] < lo_reg[a]) ? vtx[a] : lo_reg[a];
            hi_next[a] = (vtx[a] > hi_reg[a]) ? vtx[a] : hi_reg[a];
        end
    end

    // the last vertex is folded in before the box leaves
    assign push_data = {hi_next[2], hi_next[1], hi_next[0],
                        lo_next[2], lo_next[1], lo_next[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                lo_reg[a] <= POS_MAX;
                hi_reg[a] <= NEG_MIN;
            end
        end else if (accept) begin
            for (int a = 0; a < AXES; a++) begin
                lo_reg[a] <= s_last_vertex ? POS_MAX : lo_next[a];
                hi_reg[a] <= s_last_vertex ? NEG_MIN : hi_next[a];
            end
        end
    end

endmodule

### rtl/aabbs_queue.sv
// small box queue between front and back
module aabbs_queue #(
    parameter int DATA_WIDTH = 6 * aabbs_pkg::COORD_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output logic [DATA_WIDTH-1:0] pop_data
);
    import aabbs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg,  count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_pop_moves_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count not reduced on pop");
`endif

endmodule

### rtl/aabbs_back.sv
// back end: centre, squared diagonal and bit-serial square root
module aabbs_back #(
    parameter int COORD_WIDTH = aabbs_pkg::COORD_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  logic [6*COORD_WIDTH-1:0]         pop_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [aabbs_pkg::OUT_WIDTH-1:0]  m_center_x,
    output logic [aabbs_pkg::OUT_WIDTH-1:0]  m_center_y,
    output logic [aabbs_pkg::OUT_WIDTH-1:0]  m_center_z,
    output logic [aabbs_pkg::OUT_WIDTH-1:0]  m_sphere_radius
);
    import aabbs_pkg::*;

    localparam int SUM_W  = 2 * COORD_WIDTH + 2;
    localparam int ROOT_W = COORD_WIDTH + 1;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STEP_W = $clog2(ROOT_W + 1);

    back_state_t state_reg, state_next;

    logic signed [COORD_WIDTH-1:0] center_reg [AXES];
    logic        [COORD_WIDTH-1:0] d_reg      [AXES];
    logic        [2*COORD_WIDTH-1:0] prod_reg;
    logic        [SUM_W-1:0]       sum_reg;
    logic        [REM_W-1:0]       rem_reg;
    logic        [ROOT_W-1:0]      root_reg;
    logic        [1:0]             sq_cnt_reg;
    logic        [STEP_W-1:0]      step_reg;

    logic signed [COORD_WIDTH-1:0] lo [AXES];
    logic signed [COORD_WIDTH-1:0] hi [AXES];
    logic signed [COORD_WIDTH:0]   mid_sum [AXES];
    logic        [REM_W+1:0]       trial_acc, trial_sub, trial_diff;
    logic                          trial_ok;
    logic                          load;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            lo[a] = pop_data[a*COORD_WIDTH +: COORD_WIDTH];
            hi[a] = pop_data[(a+AXES)*COORD_WIDTH +: COORD_WIDTH];
            mid_sum[a] = {lo[a][COORD_WIDTH-1], lo[a]} + {hi[a][COORD_WIDTH-1], hi[a]};
        end
    end

    // one restoring root step: bring down two radicand bits, try root*4+1
    assign trial_acc  = {rem_reg, sum_reg[SUM_W-1 -: 2]};
    assign trial_sub  = {2'b00, root_reg, 2'b01};
    assign trial_diff = trial_acc - trial_sub;
    assign trial_ok   = (trial_acc >= trial_sub);

    always_comb begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    state_next = BK_SQUARE;
                end
            end
            BK_SQUARE: begin
                if (sq_cnt_reg == 2'(AXES)) begin
                    state_next = BK_ROOT;
                end
            end
            BK_ROOT: begin
                if (step_reg == STEP_W'(ROOT_W - 1)) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign load = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int a = 0; a < AXES; a++) begin
                center_reg[a] <= mid_sum[a][COORD_WIDTH:1];
                d_reg[a]      <= hi[a] - lo[a];
            end
            sum_reg    <= '0;
            sq_cnt_reg <= '0;
        end
        if (state_reg == BK_SQUARE) begin
            // product registered, then accumulated in the next cycle
            if (sq_cnt_reg != 2'(AXES)) begin
                prod_reg <= d_reg[sq_cnt_reg] * d_reg[sq_cnt_reg];
            end
            if (sq_cnt_reg != 2'd0) begin
                sum_reg <= sum_reg + SUM_W'(prod_reg);
            end
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
            rem_reg    <= '0;
            root_reg   <= '0;
            step_reg   <= '0;
        end
        if (state_reg == BK_ROOT) begin
            sum_reg  <= {sum_reg[SUM_W-3:0], 2'b00};
            step_reg <= step_reg + 1'b1;
            if (trial_ok) begin
                rem_reg  <= trial_diff[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= trial_acc[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign m_center_x      = OUT_WIDTH'(center_reg[0]);
    assign m_center_y      = OUT_WIDTH'(center_reg[1]);
    assign m_center_z      = OUT_WIDTH'(center_reg[2]);
    assign m_sphere_radius = OUT_WIDTH'(root_reg[ROOT_W-1:1]);

`ifndef SYNTHESIS
    a_pop_starts_square: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (state_reg == BK_SQUARE && sq_cnt_reg == 2'd0))
        else $error("box taken without starting the squares");
    a_root_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_ROOT) |-> (step_reg < STEP_W'(ROOT_W)))
        else $error("root step count overran");
    a_result_after_root: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == BK_ROOT))
        else $error("result raised without finishing the root");
`endif

endmodule
